### src/pmaqi_pkg.sv
package pmaqi_pkg;

  // field widths
  localparam int ConcW = 16;
  localparam int AqiW  = 16;
  localparam int CatW  = 3;
  localparam int SegW  = 3;

  // arithmetic widths
  localparam int KW    = 8;             // reduced slope numerator
  localparam int MW    = 8;             // reduced slope denominator
  localparam int NW    = 23;            // k * offset, largest is 7753875
  localparam int RShft = 24;            // reciprocal scale, 2**24 > largest numerator
  localparam int RW    = RShft + 1;     // reciprocal, one more bit for divisor one
  localparam int PW    = NW + RW;       // numerator times reciprocal
  localparam int QW    = AqiW;          // quotient
  localparam int CW    = QW + MW;       // quotient times divisor

  localparam int SegCount = 7;

  typedef logic [SegW-1:0]  seg_t;
  typedef logic [CatW-1:0]  cat_t;
  typedef logic [ConcW-1:0] conc_t;
  typedef logic [AqiW-1:0]  aqi_t;

  // category codes
  localparam cat_t CAT_GREEN  = 3'd0;
  localparam cat_t CAT_YELLOW = 3'd1;
  localparam cat_t CAT_ORANGE = 3'd2;
  localparam cat_t CAT_RED    = 3'd3;
  localparam cat_t CAT_PURPLE = 3'd4;
  localparam cat_t CAT_MAROON = 3'd5;

  // word handed from segment select to interpolation
  typedef struct packed {
    seg_t  seg;
    cat_t  cat;
    conc_t ofs;
  } seg_word_t;

  // upper concentration limit of a segment, tenths
  function automatic conc_t conc_top(input seg_t s);
    conc_t v;
    case (s)
      3'd0:    v = 16'd120;
      3'd1:    v = 16'd354;
      3'd2:    v = 16'd554;
      3'd3:    v = 16'd1504;
      3'd4:    v = 16'd2504;
      3'd5:    v = 16'd3504;
      default: v = 16'd5000;
    endcase
    return v;
  endfunction

  // lower concentration limit of a segment, tenths
  function automatic conc_t conc_base(input seg_t s);
    conc_t v;
    case (s)
      3'd0:    v = 16'd0;
      3'd1:    v = 16'd120;
      3'd2:    v = 16'd354;
      3'd3:    v = 16'd554;
      3'd4:    v = 16'd1504;
      3'd5:    v = 16'd2504;
      default: v = 16'd3504;
    endcase
    return v;
  endfunction

  // lower aqi limit of a segment, tenths
  function automatic aqi_t aqi_base(input seg_t s);
    aqi_t v;
    case (s)
      3'd0:    v = 16'd0;
      3'd1:    v = 16'd500;
      3'd2:    v = 16'd1000;
      3'd3:    v = 16'd1500;
      3'd4:    v = 16'd2000;
      3'd5:    v = 16'd3000;
      default: v = 16'd4000;
    endcase
    return v;
  endfunction

  // aqi span over concentration span, reduced: numerator
  function automatic logic [KW-1:0] slope_k(input seg_t s);
    logic [KW-1:0] v;
    case (s)
      3'd0:    v = 8'd25;    // 500 / 120
      3'd1:    v = 8'd250;   // 500 / 234
      3'd2:    v = 8'd5;     // 500 / 200
      3'd3:    v = 8'd10;    // 500 / 950
      3'd4:    v = 8'd1;     // 1000 / 1000
      3'd5:    v = 8'd1;     // 1000 / 1000
      default: v = 8'd125;   // 1000 / 1496
    endcase
    return v;
  endfunction

  // reduced denominator
  function automatic logic [MW-1:0] slope_m(input seg_t s);
    logic [MW-1:0] v;
    case (s)
      3'd0:    v = 8'd6;
      3'd1:    v = 8'd117;
      3'd2:    v = 8'd2;
      3'd3:    v = 8'd19;
      3'd4:    v = 8'd1;
      3'd5:    v = 8'd1;
      default: v = 8'd187;
    endcase
    return v;
  endfunction

  // floor(2**24 / denominator)
  function automatic logic [RW-1:0] recip(input seg_t s);
    logic [RW-1:0] v;
    case (s)
      3'd0:    v = 25'd2796202;
      3'd1:    v = 25'd143395;
      3'd2:    v = 25'd8388608;
      3'd3:    v = 25'd883011;
      3'd4:    v = 25'd16777216;
      3'd5:    v = 25'd16777216;
      default: v = 25'd89717;
    endcase
    return v;
  endfunction

  // colour category follows the segment, top two segments share maroon
  function automatic cat_t cat_of_seg(input seg_t s);
    cat_t v;
    case (s)
      3'd0:    v = CAT_GREEN;
      3'd1:    v = CAT_YELLOW;
      3'd2:    v = CAT_ORANGE;
      3'd3:    v = CAT_RED;
      3'd4:    v = CAT_PURPLE;
      default: v = CAT_MAROON;
    endcase
    return v;
  endfunction

endpackage

### src/pmaqi_seg.sv
module pmaqi_seg
  import pmaqi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  conc_t     in_conc,
  output logic      seg_valid,
  input  logic      seg_ready,
  output seg_word_t seg_word
);

  logic      v_r;
  seg_word_t word_r;
  seg_word_t word_nxt;
  seg_t      seg;

  // segment index: number of upper limits below the input, breakpoint stays low
  always_comb begin
    seg = '0;
    for (int i = 0; i < SegCount - 1; i++) begin
      if (in_conc > conc_top(seg_t'(i))) begin
        seg = seg_t'(seg + 3'd1);
      end
    end
  end

  // offset into the segment and category
  always_comb begin
    word_nxt.seg = seg;
    word_nxt.cat = cat_of_seg(seg);
    word_nxt.ofs = in_conc - conc_base(seg);
  end

  assign in_ready  = !v_r || seg_ready;
  assign seg_valid = v_r;
  assign seg_word  = word_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

### src/pmaqi_interp.sv
module pmaqi_interp
  import pmaqi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      seg_valid,
  output logic      seg_ready,
  input  seg_word_t seg_word,
  output logic      out_valid,
  input  logic      out_ready,
  output aqi_t      out_aqi,
  output cat_t      out_cat
);

  // stage a: numerator
  logic          va_r;
  seg_t          seg_a_r;
  cat_t          cat_a_r;
  logic [NW-1:0] num_a_r;
  logic [NW-1:0] num_a_nxt;
  // stage b: quotient estimate
  logic          vb_r;
  seg_t          seg_b_r;
  cat_t          cat_b_r;
  logic [NW-1:0] num_b_r;
  logic [QW-1:0] est_b_r;
  logic [PW-1:0] scaled;
  // stage c: estimate times divisor
  logic          vc_r;
  seg_t          seg_c_r;
  cat_t          cat_c_r;
  logic [NW-1:0] num_c_r;
  logic [QW-1:0] est_c_r;
  logic [CW-1:0] back_c_r;
  logic [CW-1:0] back_c_nxt;
  // stage d: output register
  logic          vd_r;
  aqi_t          aqi_d_r;
  aqi_t          aqi_d_nxt;
  cat_t          cat_d_r;
  logic [NW-1:0] rem;
  logic [QW-1:0] quo;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // stall chain, a stage takes a word when empty or moving on
  assign rdy_d     = !vd_r || out_ready;
  assign rdy_c     = !vc_r || rdy_d;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign seg_ready = rdy_a;

  // slope numerator times offset
  assign num_a_nxt = NW'(slope_k(seg_word.seg)) * NW'(seg_word.ofs);

  // reciprocal multiply, estimate is exact or one short
  assign scaled = num_a_r * recip(seg_a_r);

  // estimate times divisor for the correction
  assign back_c_nxt = est_b_r * slope_m(seg_b_r);

  // remainder check and segment base
  always_comb begin
    rem       = num_c_r - NW'(back_c_r);
    quo       = est_c_r + QW'(rem >= NW'(slope_m(seg_c_r)));
    aqi_d_nxt = aqi_base(seg_c_r) + quo;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= seg_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_d) begin
        vd_r <= vc_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      seg_a_r <= seg_word.seg;
      cat_a_r <= seg_word.cat;
      num_a_r <= num_a_nxt;
    end
    if (rdy_b) begin
      seg_b_r <= seg_a_r;
      cat_b_r <= cat_a_r;
      num_b_r <= num_a_r;
      est_b_r <= scaled[RShft +: QW];
    end
    if (rdy_c) begin
      seg_c_r  <= seg_b_r;
      cat_c_r  <= cat_b_r;
      num_c_r  <= num_b_r;
      est_c_r  <= est_b_r;
      back_c_r <= back_c_nxt;
    end
    if (rdy_d) begin
      aqi_d_r <= aqi_d_nxt;
      cat_d_r <= cat_c_r;
    end
  end

  assign out_valid = vd_r;
  assign out_aqi   = aqi_d_r;
  assign out_cat   = cat_d_r;

endmodule

### src/pm25_air_quality_index.sv
// PM2.5 to air quality index converter.
// Input channel: in_valid / in_ready carry one averaged concentration in
// in_pm25_tenths (0.1 ug/m3 units, unsigned). Output channel: out_valid /
// out_ready carry the index in out_aqi_tenths (0.1 units, truncated) and the
// colour code in out_category (0 green up to 5 maroon). Values above 500.0
// keep extrapolating along the top segment.
// The datapath is five register stages: segment select, slope multiply,
// reciprocal multiply, back multiply, remainder correction into the output
// register. An accepted word passes through each of these in turn to the
// output. One word a cycle is taken and delivered while out_ready is high.
// When the receiver holds out_ready low the stages fill one by one; in_ready
// drops only once every stage holds a word, and nothing is dropped or sent
// twice. Reset (rst_n low, synchronous) empties all stages; no other state
// is kept.
module pm25_air_quality_index
  import pmaqi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ConcW-1:0]    in_pm25_tenths,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [AqiW-1:0]     out_aqi_tenths,
  output logic [CatW-1:0]     out_category
);

  logic      seg_valid;
  logic      seg_ready;
  seg_word_t seg_word;

  // segment select stage
  pmaqi_seg u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_conc   (in_pm25_tenths),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg_word  (seg_word)
  );

  // interpolation stages
  pmaqi_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg_word  (seg_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_aqi   (out_aqi_tenths),
    .out_cat   (out_category)
  );

endmodule
